[rtl/rse_pkg.sv]
// ---------------------------------------------------------------------------
// rse_pkg: shared types and constants of the reflector segment extractor
// Field widths, accumulator sizes, angle constants, register indexes and the
// command/status structs between the controller and the datapath.
// ---------------------------------------------------------------------------
package rse_pkg;

	// segment length limit and derived widths
	localparam int MAX_SEGMENT_POINTS = 1024;
	localparam int CNT_W  = $clog2(MAX_SEGMENT_POINTS + 1);
	localparam int RANGE_W = 16;
	localparam int ANGLE_W = 17;
	localparam int INTEN_W = 8;
	localparam int RSUM_W = RANGE_W + $clog2(MAX_SEGMENT_POINTS);
	localparam int ASUM_W = ANGLE_W + $clog2(MAX_SEGMENT_POINTS);
	localparam int DIV_W  = ASUM_W;
	localparam int DIV_STEPS = DIV_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int BEAR_W = ANGLE_W + 2;

	// angle constants, units of 2^-14 rad
	localparam logic signed [BEAR_W-1:0] HALF_PI_Q = 19'sd25736;
	localparam logic signed [BEAR_W-1:0] PI_Q      = 19'sd51472;
	localparam logic signed [BEAR_W-1:0] TWO_PI_Q  = 19'sd102944;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_GAP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE     = 2'd2;

	localparam logic [INTEN_W-1:0] RST_INTENSITY_THR = 8'd1;
	localparam logic [RANGE_W-1:0] RST_RANGE_GAP     = 16'd100;
	localparam logic [RANGE_W-1:0] RST_MIN_RANGE     = 16'd50;

	typedef logic [RANGE_W-1:0] range_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic [INTEN_W-1:0] inten_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // input ready
		logic upd;        // input word accepted
		logic add;        // point continues the segment
		logic start;      // point opens a new segment
		logic open_next;  // segment open after this point
		logic div_load;   // load divider from accumulators
		logic div_step;   // one divider iteration
		logic div_fin;    // form result into a slot
		logic fin_sel;
		logic push;       // load output register
		logic push_sel;
		logic push_last;
	} rse_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_valid;
		logic open;
		logic bright;
		logic near;
		logic eos;
		logic kept0;
		logic kept1;
		logic out_free;
	} rse_stat_t;

endpackage

[rtl/rse_if.sv]
// ---------------------------------------------------------------------------
// rse_if: channel interfaces of the reflector segment extractor
// Scan point channel and feature channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface rse_point_if;
	import rse_pkg::*;
	logic   valid;
	logic   ready;
	range_t range_mm;
	angle_t angle;
	inten_t intensity;
	logic   valid_req;
	logic   end_of_scan;

	modport source (output valid, output range_mm, output angle, output intensity,
		output valid_req, output end_of_scan, input ready);
	modport sink (input valid, input range_mm, input angle, input intensity,
		input valid_req, input end_of_scan, output ready);
endinterface

interface rse_feature_if;
	import rse_pkg::*;
	logic   valid;
	logic   ready;
	range_t feature_range;
	angle_t feature_bearing;
	logic   last_of_run;

	modport source (output valid, output feature_range, output feature_bearing,
		output last_of_run, input ready);
	modport sink (input valid, input feature_range, input feature_bearing,
		input last_of_run, output ready);
endinterface

[rtl/reflector_segment_extractor_core.sv]
// ---------------------------------------------------------------------------
// reflector_segment_extractor_core: reflective segment features from scans
// Groups bright, close-range scan points into segments and emits the mean
// range and bearing of each closed segment.
// ---------------------------------------------------------------------------
// Usage:
//  points   : one scan point per word (range, angle, intensity, valid flag,
//             end of scan). Ready is high while the block is idle.
//  features : zero, one or two words per point; last_of_run marks the final
//             word caused by a point.
//  cfg_*    : register write port, index 0 intensity threshold, 1 range gap,
//             2 minimum mean range; write only while idle.
// Sequence: a point that closes no segment leaves the block idle. A closed
//  segment loads the divider with the point, iterates, finishes; a close at
//  end of scan reloads (in a load state if alone), iterates, finishes; emit
//  states then hand the words to the output register, one a cycle if free.
// Reset clears the open segment, the output register and restores the
//  register defaults. A stalled receiver holds one word in the output
//  register; the block takes the next point meanwhile and waits only when
//  it has a further word to hand over.
// ---------------------------------------------------------------------------
module reflector_segment_extractor_core (
	input  logic                 clk,
	input  logic                 arst_n,
	rse_point_if.sink            points,
	rse_feature_if.source        features,
	input  logic                 cfg_we,
	input  logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rse_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rse_pkg::*;

	rse_cmd_t  cmd;
	rse_stat_t stat;

	rse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	rse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.points    (points),
		.features  (features),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat)
	);

	// output is loaded only into a free register
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |-> stat.out_free)
		else $error("feature word pushed over a held word");

	// no point is taken while results are in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.div_step || cmd.div_fin) |-> !points.ready)
		else $error("point accepted during division or output");

	// a result slot is formed right after the last divider iteration
	assert property (@(posedge clk) disable iff (!arst_n) cmd.div_fin |-> $past(cmd.div_step))
		else $error("divider finish without preceding iteration");

endmodule

[rtl/rse_dp.sv]
// ---------------------------------------------------------------------------
// rse_dp: datapath of the reflector segment extractor
// Config registers, segment accumulators, two-lane serial divider, result
// slots and the output register.
// ---------------------------------------------------------------------------
module rse_dp (
	input  logic              clk,
	input  logic              arst_n,
	rse_point_if.sink         points,
	rse_feature_if.source     features,
	input  logic              cfg_we,
	input  logic [rse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rse_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  rse_pkg::rse_cmd_t  cmd,
	output rse_pkg::rse_stat_t stat
);
	import rse_pkg::*;

	inten_t thr_q;
	range_t gap_q;
	range_t min_q;

	logic                     open_q;
	range_t                   first_q;
	logic [RSUM_W-1:0]        rsum_q;
	logic signed [ASUM_W-1:0] asum_q;
	logic [CNT_W-1:0]         cnt_q;

	logic [DIV_W-1:0] rq_q, aq_q;
	logic [CNT_W-1:0] rr_q, ar_q, dn_q;
	logic             aneg_q;

	range_t slot_r_q [2];
	angle_t slot_b_q [2];
	logic   kept_q   [2];

	logic   out_valid_q;
	range_t out_r_q;
	angle_t out_b_q;
	logic   out_last_q;

	range_t diff;
	logic   out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RST_INTENSITY_THR;
			gap_q <= RST_RANGE_GAP;
			min_q <= RST_MIN_RANGE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTENSITY_THR: thr_q <= cfg_wdata[INTEN_W-1:0];
				CFG_RANGE_GAP:     gap_q <= cfg_wdata[RANGE_W-1:0];
				CFG_MIN_RANGE:     min_q <= cfg_wdata[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// point classification
	always_comb begin
		diff = (points.range_mm > first_q) ? points.range_mm - first_q
			: first_q - points.range_mm;
	end

	assign points.ready  = cmd.take;
	assign out_free      = !out_valid_q || features.ready;
	assign stat.in_valid = points.valid;
	assign stat.open     = open_q;
	assign stat.bright   = points.valid_req && (points.intensity >= thr_q);
	assign stat.near     = diff < gap_q;
	assign stat.eos      = points.end_of_scan;
	assign stat.kept0    = kept_q[0];
	assign stat.kept1    = kept_q[1];
	assign stat.out_free = out_free;

	// segment open flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (cmd.upd) begin
			open_q <= cmd.open_next;
		end
	end

	// accumulators; count saturates at the segment limit
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			first_q <= points.range_mm;
			rsum_q  <= RSUM_W'(points.range_mm);
			asum_q  <= ASUM_W'(points.angle);
			cnt_q   <= CNT_W'(1);
		end else if (cmd.add && (cnt_q < CNT_W'(MAX_SEGMENT_POINTS))) begin
			rsum_q <= rsum_q + RSUM_W'(points.range_mm);
			asum_q <= asum_q + ASUM_W'(points.angle);
			cnt_q  <= cnt_q + CNT_W'(1);
		end
	end

	// serial restoring divider, range and angle magnitude lanes
	logic [CNT_W:0] rt, at;
	always_comb begin
		rt = {rr_q, rq_q[DIV_W-1]};
		at = {ar_q, aq_q[DIV_W-1]};
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rq_q   <= DIV_W'(rsum_q);
			aq_q   <= asum_q[ASUM_W-1] ? DIV_W'(-asum_q) : DIV_W'(asum_q);
			aneg_q <= asum_q[ASUM_W-1];
			rr_q   <= '0;
			ar_q   <= '0;
			dn_q   <= cnt_q;
		end else if (cmd.div_step) begin
			if (rt >= {1'b0, dn_q}) begin
				rr_q <= CNT_W'(rt - {1'b0, dn_q});
				rq_q <= {rq_q[DIV_W-2:0], 1'b1};
			end else begin
				rr_q <= rt[CNT_W-1:0];
				rq_q <= {rq_q[DIV_W-2:0], 1'b0};
			end
			if (at >= {1'b0, dn_q}) begin
				ar_q <= CNT_W'(at - {1'b0, dn_q});
				aq_q <= {aq_q[DIV_W-2:0], 1'b1};
			end else begin
				ar_q <= at[CNT_W-1:0];
				aq_q <= {aq_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	// mean angle with sign, shift by pi/2 and wrap
	logic [ANGLE_W:0]          mag;
	logic signed [ANGLE_W:0]   ma;
	logic signed [BEAR_W-1:0]  d, dw;
	always_comb begin
		mag = {1'b0, aq_q[ANGLE_W-1:0]};
		ma  = aneg_q ? -$signed(mag) : $signed(mag);
		d   = BEAR_W'(ma) - HALF_PI_Q;
		if (d < -PI_Q) begin
			dw = d + TWO_PI_Q;
		end else if (d > PI_Q) begin
			dw = d - TWO_PI_Q;
		end else begin
			dw = d;
		end
	end

	// result slots
	always_ff @(posedge clk) begin
		if (cmd.div_fin) begin
			slot_r_q[cmd.fin_sel] <= rq_q[RANGE_W-1:0];
			slot_b_q[cmd.fin_sel] <= dw[ANGLE_W-1:0];
			kept_q[cmd.fin_sel]   <= rq_q[RANGE_W-1:0] > min_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (features.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_r_q    <= slot_r_q[cmd.push_sel];
			out_b_q    <= slot_b_q[cmd.push_sel];
			out_last_q <= cmd.push_last;
		end
	end

	assign features.valid           = out_valid_q;
	assign features.feature_range   = out_r_q;
	assign features.feature_bearing = out_b_q;
	assign features.last_of_run     = out_last_q;

endmodule

[rtl/rse_ctrl.sv]
// ---------------------------------------------------------------------------
// rse_ctrl: controller of the reflector segment extractor
// Decides per point what happens to the segment, sequences the divisions
// of closed segments and hands their results to the output register.
// ---------------------------------------------------------------------------
module rse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  rse_pkg::rse_stat_t stat,
	output rse_pkg::rse_cmd_t  cmd
);
	import rse_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD2 = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_EMIT0 = 3'd4;
	localparam logic [2:0] S_EMIT1 = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              have1_q, have2_q, sel_q;

	logic accept, cont, close1, open_new, close2;
	logic emit0, emit1;

	// point decision
	always_comb begin
		accept   = (state_q == S_IDLE) && stat.in_valid;
		cont     = stat.open && stat.bright && stat.near;
		close1   = stat.open && !cont;
		open_new = stat.bright && !cont;
		close2   = stat.eos && (cont || open_new);
		emit0    = have1_q && stat.kept0;
		emit1    = have2_q && stat.kept1;
	end

	// commands and next state
	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cmd.take      = (state_q == S_IDLE);
		cmd.upd       = accept;
		cmd.add       = accept && cont;
		cmd.start     = accept && open_new;
		cmd.open_next = (cont || open_new) && !stat.eos;
		cmd.fin_sel   = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && close1) begin
					cmd.div_load = 1'b1;
					state_d      = S_DIV;
				end else if (accept && close2) begin
					state_d = S_LOAD2;
				end
			end
			S_LOAD2: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.div_fin = 1'b1;
				state_d     = (!sel_q && have2_q) ? S_LOAD2 : S_EMIT0;
			end
			S_EMIT0: begin
				if (!emit0) begin
					state_d = S_EMIT1;
				end else if (stat.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_sel  = 1'b0;
					cmd.push_last = !emit1;
					state_d       = S_EMIT1;
				end
			end
			S_EMIT1: begin
				if (!emit1) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_sel  = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, step counter and per-point flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			have1_q <= 1'b0;
			have2_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				have1_q <= close1;
				have2_q <= close2;
				sel_q   <= 1'b0;
			end else if (state_q == S_LOAD2) begin
				sel_q <= 1'b1;
			end
			if (cmd.div_load) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

endmodule

[tb/reflector_segment_extractor_core_test.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reflector_segment_extractor_core_test: self-checking bench for the core
// Streams scan points into the block under several register settings and
// checks every feature word against an in-bench segment predictor. Both
// channels idle at random; the final phase runs with no idling.
// ---------------------------------------------------------------------------
module reflector_segment_extractor_core_test;
	import rse_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 80;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		range_t rng;
		angle_t ang;
		inten_t inten;
		logic   vld;
		logic   eos;
	} scan_pt_t;

	typedef struct {
		range_t rng;
		angle_t bear;
		logic   last;
	} feat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rse_point_if points();
	rse_feature_if features();

	reflector_segment_extractor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points),
		.features(features),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// points waiting to be sent, features still owed by the block
	scan_pt_t scan_q[$];
	feat_t    want_feat[$];

	// predictor copy of the registers and the open segment
	inten_t thr;
	range_t gap_thr;
	range_t min_rng;
	bit     seg_open;
	range_t first_rng;
	longint rng_sum;
	longint ang_sum;
	int     pt_cnt;

	int  n_err;
	int  cycles;
	bit  pt_hs;
	bit  calm;
	int  src_gap;
	int  snk_gap;
	scan_pt_t nxt;

	// --------------------------------------------------------------------
	// segment predictor
	// --------------------------------------------------------------------
	function automatic void open_seg(range_t r, longint a);
		seg_open  = 1'b1;
		first_rng = r;
		rng_sum   = longint'(r);
		ang_sum   = a;
		pt_cnt    = 1;
	endfunction

	// closes the open segment, appends its feature unless dropped
	function automatic void close_seg(ref feat_t outs[$]);
		longint n;
		longint mean_r;
		longint mean_a;
		longint d;
		feat_t  f;
		if (!seg_open)
			return;
		seg_open = 1'b0;
		n = (pt_cnt == 0) ? 1 : pt_cnt;
		mean_r = rng_sum / n;
		mean_a = ang_sum / n;
		if (mean_r <= longint'(min_rng))
			return;
		d = mean_a - longint'(HALF_PI_Q);
		if (d < -longint'(PI_Q))
			d += longint'(TWO_PI_Q);
		else if (d > longint'(PI_Q))
			d -= longint'(TWO_PI_Q);
		f.rng  = range_t'(mean_r);
		f.bear = angle_t'(d);
		f.last = 1'b0;
		outs.push_back(f);
	endfunction

	function automatic void fold_point(scan_pt_t p);
		feat_t  outs[$];
		bit     bright;
		longint a;
		longint diff;
		bright = p.vld && (p.inten >= thr);
		a = longint'(p.ang);
		if (seg_open) begin
			diff = (p.rng > first_rng) ? longint'(p.rng) - longint'(first_rng)
				: longint'(first_rng) - longint'(p.rng);
			if (bright && diff < longint'(gap_thr)) begin
				// count saturates, sums freeze with it
				if (pt_cnt < MAX_SEGMENT_POINTS) begin
					rng_sum += longint'(p.rng);
					ang_sum += a;
					pt_cnt++;
				end
			end else begin
				close_seg(outs);
				if (bright)
					open_seg(p.rng, a);
			end
		end else if (bright) begin
			open_seg(p.rng, a);
		end
		if (p.eos)
			close_seg(outs);
		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
		foreach (outs[k])
			want_feat.push_back(outs[k]);
	endfunction

	// --------------------------------------------------------------------
	// monitor: point acceptance feeds the predictor, feature words are checked
	// --------------------------------------------------------------------
	always @(posedge clk) begin
		feat_t w;
		cycles++;
		if (cycles >= LIMIT) begin
			$display("reflector_segment_extractor_core_test: done, errors");
			$finish;
		end else if (arst_n) begin
			pt_hs <= points.valid && points.ready;
			if (features.valid && features.ready) begin
				if (want_feat.size() == 0) begin
					$error("unexpected feature word: range %0d bearing %0d last %0b",
						features.feature_range, features.feature_bearing,
						features.last_of_run);
					n_err++;
				end else begin
					w = want_feat.pop_front();
					if (features.feature_range !== w.rng) begin
						$error("feature_range: expected %0d, got %0d",
							w.rng, features.feature_range);
						n_err++;
					end
					if (features.feature_bearing !== w.bear) begin
						$error("feature_bearing: expected %0d, got %0d",
							w.bear, features.feature_bearing);
						n_err++;
					end
					if (features.last_of_run !== w.last) begin
						$error("last_of_run: expected %0b, got %0b",
							w.last, features.last_of_run);
						n_err++;
					end
				end
			end
			if (points.valid && points.ready) begin
				nxt.rng   = points.range_mm;
				nxt.ang   = points.angle;
				nxt.inten = points.intensity;
				nxt.vld   = points.valid_req;
				nxt.eos   = points.end_of_scan;
				fold_point(nxt);
			end
		end
	end

	// --------------------------------------------------------------------
	// driver: point source and feature sink, with random idle bursts
	// --------------------------------------------------------------------
	always @(negedge clk) begin
		scan_pt_t p;
		if (!arst_n) begin
			points.valid   <= 1'b0;
			features.ready <= 1'b0;
		end else begin
			if (!points.valid || pt_hs) begin
				if (src_gap > 0) begin
					src_gap--;
					points.valid <= 1'b0;
				end else if (scan_q.size() == 0) begin
					points.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 6) == 0) begin
					src_gap = $urandom_range(0, 4);
					points.valid <= 1'b0;
				end else begin
					p = scan_q.pop_front();
					points.range_mm    <= p.rng;
					points.angle       <= p.ang;
					points.intensity   <= p.inten;
					points.valid_req   <= p.vld;
					points.end_of_scan <= p.eos;
					points.valid       <= 1'b1;
				end
			end
			if (calm) begin
				features.ready <= 1'b1;
			end else if (snk_gap > 0) begin
				snk_gap--;
				features.ready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				snk_gap = $urandom_range(0, 4);
				features.ready <= 1'b0;
			end else begin
				features.ready <= 1'b1;
			end
		end
	end

	// --------------------------------------------------------------------
	// stimulus helpers
	// --------------------------------------------------------------------
	task automatic add_pt(int r, int a, int i, bit v, bit e);
		scan_pt_t p;
		p.rng   = range_t'(r);
		p.ang   = angle_t'(a);
		p.inten = inten_t'(i);
		p.vld   = v;
		p.eos   = e;
		scan_q.push_back(p);
	endtask

	// wait until every point is sent and every feature seen, then let the
	// divider finish any dropped segment
	task automatic settle();
		do @(posedge clk);
		while (scan_q.size() != 0 || points.valid || want_feat.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_INTENSITY_THR: thr = val[INTEN_W-1:0];
			CFG_RANGE_GAP: gap_thr = val;
			CFG_MIN_RANGE: min_rng = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(int i_thr, int gap, int mmin);
		// upper byte of the intensity write is junk and must be ignored
		write_reg(CFG_INTENSITY_THR, {8'($urandom), 8'(i_thr)});
		write_reg(CFG_RANGE_GAP, 16'(gap));
		write_reg(CFG_MIN_RANGE, 16'(mmin));
		write_reg(CFG_SPARE, 16'($urandom));
	endtask

	// mostly well-formed segments, plus noise, dim/invalid points and flushes
	task automatic gen_scans(int n);
		int made;
		int kind;
		int len;
		int r0;
		int r;
		int c;
		int g;
		int off;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				len = $urandom_range(1, 8);
				r0  = $urandom_range(0, 65535);
				c   = int'($urandom_range(0, 100000)) - 50000;
				g   = int'(gap_thr);
				for (int k = 0; k < len; k++) begin
					off = (k > 0 && g > 1) ? int'($urandom_range(0, 2 * (g - 1))) - (g - 1) : 0;
					r = r0 + off;
					if (r < 0 || r > 65535)
						r = r0;
					add_pt(r, c + int'($urandom_range(0, 2000)) - 1000,
						$urandom_range(255, thr), 1'b1,
						(k == len - 1) && ($urandom_range(0, 3) == 0));
					made++;
				end
			end else if (kind == 7) begin
				add_pt($urandom_range(0, 65535), int'($urandom_range(0, 102944)) - 51472,
					$urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 7) == 0);
				made++;
			end else if (kind == 8) begin
				if (thr > 0 && $urandom_range(0, 1) == 0)
					add_pt($urandom_range(0, 65535), int'($urandom_range(0, 102944)) - 51472,
						$urandom_range(0, thr - 1), 1'b1, 1'b0);
				else
					add_pt($urandom_range(0, 65535), int'($urandom_range(0, 102944)) - 51472,
						$urandom_range(0, 255), 1'b0, 1'b0);
				made++;
			end else begin
				add_pt($urandom_range(0, 65535), int'($urandom_range(0, 102944)) - 51472,
					$urandom_range(0, 255), $urandom_range(0, 1), 1'b1);
				made++;
			end
		end
	endtask

	// --------------------------------------------------------------------
	// test sequence
	// --------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		points.valid       = 1'b0;
		points.range_mm    = '0;
		points.angle       = '0;
		points.intensity   = '0;
		points.valid_req   = 1'b0;
		points.end_of_scan = 1'b0;
		features.ready     = 1'b0;
		thr       = RST_INTENSITY_THR;
		gap_thr   = RST_RANGE_GAP;
		min_rng   = RST_MIN_RANGE;
		seg_open  = 1'b0;
		first_rng = '0;
		rng_sum   = 0;
		ang_sum   = 0;
		pt_cnt    = 0;
		n_err     = 0;
		cycles    = 0;
		calm      = 1'b0;
		src_gap   = 0;
		snk_gap   = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed points under the reset register values
		add_pt(65535, 0, 255, 0, 0);        // invalid reading
		add_pt(0, 0, 0, 1, 0);              // dim reading
		add_pt(1000, 51472, 255, 1, 0);     // opens
		add_pt(1099, 51472, 1, 1, 0);       // just inside the gap
		add_pt(901, 51470, 200, 1, 0);
		add_pt(1100, -51472, 255, 1, 0);    // gap reached: close and reopen
		add_pt(1100, -51472, 255, 1, 1);    // flush, bearing wraps up
		add_pt(30, 100, 1, 1, 0);
		add_pt(40, 100, 1, 1, 1);           // mean below minimum: dropped
		add_pt(50, 7, 9, 1, 1);             // mean equal to minimum: dropped
		add_pt(51, 7, 9, 1, 1);
		add_pt(2000, 0, 77, 1, 0);
		add_pt(5000, -100, 77, 1, 1);       // breaking point at end of scan: two words
		add_pt(3000, 12345, 5, 1, 0);
		add_pt(3000, 12345, 0, 1, 1);       // dim point breaks, then flush
		add_pt(65535, 1, 255, 1, 0);
		add_pt(65535, 1, 255, 0, 0);        // invalid point breaks
		add_pt(0, -1, 255, 0, 1);           // flush with nothing open
		add_pt(500, -1, 3, 1, 0);
		add_pt(500, -2, 3, 1, 1);           // mean angle truncates toward zero
		add_pt(0, 0, 255, 1, 1);            // zero range
		add_pt(20, 0, 1, 1, 0);
		add_pt(900, 300, 1, 1, 1);          // dropped segment, then kept one
		settle();

		// every valid point bright, huge gap, minimum range zero
		set_regs(0, 65535, 0);
		gen_scans(150);
		settle();

		// only full intensity counts, every point breaks, everything dropped
		set_regs(255, 0, 65535);
		gen_scans(150);
		settle();

		set_regs($urandom_range(1, 200), $urandom_range(20, 2000), $urandom_range(0, 3000));
		gen_scans(150);
		settle();

		// moderate threshold and gap
		set_regs(10, 500, 100);
		gen_scans(150);
		settle();

		// last phase: no idling on either side
		set_regs($urandom_range(1, 60), $urandom_range(100, 5000), $urandom_range(0, 500));
		calm = 1'b1;
		gen_scans(150);
		settle();

		if (n_err == 0)
			$display("reflector_segment_extractor_core_test: done, clean");
		else
			$display("reflector_segment_extractor_core_test: done, errors");
		$finish;
	end

endmodule
